// ===== design/x86d_pkg.sv =====
// x86d_pkg: shared types, constants and opcode classification for the 8086 decoder
// no dependencies
package x86d_pkg;

	localparam int QueueDepth = 2;

	localparam logic [4:0] GROUP_NONE = 5'd31;

	typedef struct packed {
		logic [4:0]  group;
		logic [7:0]  opcode;
		logic [1:0]  mode;
		logic [2:0]  reg_field;
		logic [2:0]  rm_field;
		logic        wide;
		logic        to_register;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
		logic        bad_opcode;
	} result_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [2:0]  taken;
		logic        bad;
	} raw_t;

	function automatic logic [4:0] classify(input logic [7:0] op);
		logic [7:0] h6, h7, h4, h5;
		h6 = op & 8'hFC;
		h7 = op & 8'hFE;
		h4 = op & 8'hF0;
		h5 = op & 8'hF8;
		priority if (h6 == 8'h88 || h6 == 8'h38 || h6 == 8'h28 || h6 == 8'h18 ||
				h6 == 8'h10 || h6 == 8'h00) return 5'd0;
		else if (h4 == 8'hB0) return 5'd1;
		else if (h7 == 8'hC6) return 5'd2;
		else if (h6 == 8'h80) return 5'd3;
		else if (h7 == 8'h04 || h7 == 8'h14 || h7 == 8'h1C || h7 == 8'h3C ||
				h7 == 8'h2C) return 5'd4;
		else if (op == 8'hFF) return 5'd5;
		else if (op == 8'h8F) return 5'd6;
		else if (h4 == 8'h50) return 5'd7;
		else if (h7 == 8'h86) return 5'd8;
		else if (h6 == 8'hD0) return 5'd9;
		else if (h5 == 8'h90) return 5'd10;
		else if (h5 == 8'h40 || h5 == 8'h48) return 5'd11;
		else if (h7 == 8'hFE || h7 == 8'hF6) return 5'd12;
		else if (op == 8'h8D || op == 8'hC5 || op == 8'hC4) return 5'd13;
		else if (h6 == 8'h20) return 5'd14;
		else if (h7 == 8'h24) return 5'd15;
		else if (op == 8'h1F || op == 8'h0E || op == 8'hD7 || op == 8'h9F ||
				op == 8'h9E || op == 8'h9C || op == 8'h9D || op == 8'h37 ||
				op == 8'h27 || op == 8'h3F || op == 8'h2F || op == 8'h98 ||
				op == 8'h99 || op == 8'hEC || op == 8'hED || op == 8'hEE ||
				op == 8'hEF) return 5'd16;
		else if (op == 8'hE0 || op == 8'hE1 || op == 8'hE2 || op == 8'hE3 ||
				op == 8'hD4 || op == 8'hD5) return 5'd17;
		else if (op == 8'hE4 || op == 8'hE5 || op == 8'hE6 || op == 8'hE7) return 5'd18;
		else if (op == 8'hA0 || op == 8'hA1 || op == 8'hA2 || op == 8'hA3) return 5'd19;
		else if (h4 == 8'h70) return 5'd17;
		else return GROUP_NONE;
	endfunction

	function automatic logic has_modrm(input logic [4:0] g);
		return g == 5'd0 || g == 5'd2 || g == 5'd3 || g == 5'd5 || g == 5'd6 ||
			g == 5'd8 || g == 5'd9 || g == 5'd12 || g == 5'd13 || g == 5'd14;
	endfunction

	function automatic logic [1:0] disp_len(input logic [4:0] g, input logic [7:0] modrm);
		if (!has_modrm(g)) return (g == 5'd19) ? 2'd2 : 2'd0;
		if (modrm[7:6] == 2'd3) return 2'd0;
		if (modrm[7:6] == 2'd0) return (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
		return modrm[7:6];
	endfunction

	function automatic logic [1:0] imm_len(input logic [4:0] g, input logic [7:0] op);
		unique case (g)
			5'd1: return op[3] ? 2'd2 : 2'd1;
			5'd2, 5'd4, 5'd15: return op[0] ? 2'd2 : 2'd1;
			5'd3: return (op[1:0] == 2'd1) ? 2'd2 : 2'd1;
			5'd17, 5'd18: return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

endpackage

// ===== design/x86d_if.sv =====
// x86d_if: valid/ready channel carrying one payload
// depends on nothing; payload type set by parameter
interface x86d_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/x86d_front.sv =====
// x86d_front: byte collector, gathers opcode, modrm and tail bytes per instruction
// depends on x86d_pkg
module x86d_front import x86d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       push,
	input  logic       full,
	output raw_t       raw
);
	typedef enum logic [2:0] {
		PH_OPCODE = 3'b001,
		PH_MODRM  = 3'b010,
		PH_TAIL   = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  op_q, modrm_q;
	logic [15:0] disp_q, imm_q;
	logic [2:0]  left_q, taken_q, pos_q;
	logic [1:0]  dlen_q;
	logic [4:0]  g_in, g_held;
	logic [2:0]  tail_in;
	logic        fire;
	logic [15:0] disp_n, imm_n;

	assign in_ready = !full;
	assign fire = in_valid && in_ready;
	assign g_in = classify(in_byte);
	assign g_held = classify(op_q);

	always_comb begin
		disp_n = disp_q;
		imm_n = imm_q;
		if ({1'b0, pos_q} < {2'b0, dlen_q}) begin
			if (pos_q[0]) disp_n[15:8] = disp_q[15:8] | in_byte;
			else disp_n[7:0] = disp_q[7:0] | in_byte;
		end else begin
			if (pos_q[0] ^ dlen_q[0]) imm_n[15:8] = imm_q[15:8] | in_byte;
			else imm_n[7:0] = imm_q[7:0] | in_byte;
		end
	end

	always_comb begin
		push = 1'b0;
		raw = '{opcode: op_q, modrm: modrm_q, disp: disp_q, imm: imm_q,
			taken: taken_q, bad: 1'b0};
		tail_in = 3'd0;
		unique case (phase_q)
			PH_MODRM: begin
				tail_in = {1'b0, disp_len(g_held, in_byte)} + {1'b0, imm_len(g_held, op_q)};
				raw.modrm = in_byte;
				raw.taken = 3'd2;
				push = fire && tail_in == 3'd0;
			end
			PH_TAIL: begin
				raw.disp = disp_n;
				raw.imm = imm_n;
				raw.taken = taken_q + 3'd1;
				push = fire && left_q == 3'd1;
			end
			default: begin
				tail_in = {1'b0, disp_len(g_in, 8'd0)} + {1'b0, imm_len(g_in, in_byte)};
				raw = '{opcode: in_byte, modrm: 8'd0, disp: 16'd0, imm: 16'd0,
					taken: 3'd1, bad: g_in == GROUP_NONE};
				push = fire && (g_in == GROUP_NONE ||
					(!has_modrm(g_in) && tail_in == 3'd0));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q <= 8'd0;
			modrm_q <= 8'd0;
			disp_q <= 16'd0;
			imm_q <= 16'd0;
			dlen_q <= 2'd0;
			left_q <= 3'd0;
			pos_q <= 3'd0;
			taken_q <= 3'd0;
		end else if (fire) begin
			unique case (phase_q)
				PH_MODRM: begin
					modrm_q <= in_byte;
					taken_q <= 3'd2;
					dlen_q <= disp_len(g_held, in_byte);
					pos_q <= 3'd0;
					left_q <= tail_in;
					phase_q <= (tail_in == 3'd0) ? PH_OPCODE : PH_TAIL;
				end
				PH_TAIL: begin
					disp_q <= disp_n;
					imm_q <= imm_n;
					taken_q <= taken_q + 3'd1;
					pos_q <= pos_q + 3'd1;
					left_q <= left_q - 3'd1;
					if (left_q == 3'd1) phase_q <= PH_OPCODE;
				end
				default: begin
					op_q <= in_byte;
					modrm_q <= 8'd0;
					disp_q <= 16'd0;
					imm_q <= 16'd0;
					taken_q <= 3'd1;
					pos_q <= 3'd0;
					dlen_q <= disp_len(g_in, 8'd0);
					left_q <= tail_in;
					if (g_in == GROUP_NONE) phase_q <= PH_OPCODE;
					else if (has_modrm(g_in)) phase_q <= PH_MODRM;
					else if (tail_in != 3'd0) phase_q <= PH_TAIL;
					else phase_q <= PH_OPCODE;
				end
			endcase
		end
	end
endmodule

// ===== design/x86d_queue.sv =====
// x86d_queue: small fifo of collected instructions between front and back
// depends on x86d_pkg
module x86d_queue import x86d_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  raw_t push_data,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output raw_t pop_data
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	raw_t              mem_q [Depth];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;

	assign full = cnt_q == (AW+1)'(Depth);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== design/x86d_back.sv =====
// x86d_back: field extraction of a collected instruction into a result register
// depends on x86d_pkg
module x86d_back import x86d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    raw_valid,
	output logic    pop,
	input  raw_t    raw,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	result_t r;
	logic [4:0] g;
	logic       valid_q;

	assign pop = raw_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign g = classify(raw.opcode);

	always_comb begin
		r = '0;
		r.opcode = raw.opcode;
		r.length = raw.taken;
		if (raw.bad) begin
			r.bad_opcode = 1'b1;
		end else begin
			r.group = g;
			r.wide = raw.opcode[0];
			r.displacement = raw.disp;
			r.immediate = raw.imm;
			if (has_modrm(g)) begin
				r.mode = raw.modrm[7:6];
				r.reg_field = raw.modrm[5:3];
				r.rm_field = raw.modrm[2:0];
			end
			if (g == 5'd1) begin
				r.reg_field = raw.opcode[2:0];
				r.wide = raw.opcode[3];
			end
			if (g == 5'd7 || g == 5'd10 || g == 5'd11) begin
				r.reg_field = raw.opcode[2:0];
				r.wide = 1'b1;
			end
			if (g == 5'd0 || g == 5'd14) r.to_register = raw.opcode[1];
			if (disp_len(g, raw.modrm) == 2'd1)
				r.displacement = {{8{raw.disp[7]}}, raw.disp[7:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_data <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (out_ready) valid_q <= 1'b0;
	end
endmodule

// ===== design/x86_16_instruction_decoder_top.sv =====
// 8086 instruction decoder: one code byte accepted per cycle while the queue is not full
// the last instruction byte is written into the queue, then into the result register, before the result request
// throughput: one byte per cycle unless the queue is full, results as instructions complete
// the front collects bytes; a two-entry queue and result register decouple output
// arst_n clears the byte phase, queue pointers and result valid
// depends on x86d_pkg, x86d_if, x86d_front, x86d_queue, x86d_back
module x86_16_instruction_decoder_top import x86d_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input logic clk,
	input logic arst_n,
	x86d_if.sink   in_ch,
	x86d_if.source out_ch
);
	logic push, full, pop, pvalid;
	raw_t wdata, rdata;

	x86d_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.data),
		.push, .full, .raw(wdata)
	);

	x86d_queue #(.Depth(Depth)) u_queue (
		.clk, .arst_n, .push, .push_data(wdata), .full,
		.pop_valid(pvalid), .pop, .pop_data(rdata)
	);

	x86d_back u_back (
		.clk, .arst_n, .raw_valid(pvalid), .pop, .raw(rdata),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule
